### rtl/core/mtep_pkg.sv
`timescale 1ns / 1ps
package mtep_pkg;

  localparam logic [3:0] PH_DELTA      = 4'd0;
  localparam logic [3:0] PH_STATUS     = 4'd1;
  localparam logic [3:0] PH_CH1        = 4'd2;
  localparam logic [3:0] PH_CH2        = 4'd3;
  localparam logic [3:0] PH_META_TYPE  = 4'd4;
  localparam logic [3:0] PH_META_LEN   = 4'd5;
  localparam logic [3:0] PH_TEMPO      = 4'd6;
  localparam logic [3:0] PH_SKIP       = 4'd7;
  localparam logic [3:0] PH_SYSEX_LEN  = 4'd8;
  localparam logic [3:0] PH_SYSEX_BODY = 4'd9;

  localparam logic [3:0] EV_NOTEOFF   = 4'd0;
  localparam logic [3:0] EV_NOTEON    = 4'd1;
  localparam logic [3:0] EV_KEYPRESS  = 4'd2;
  localparam logic [3:0] EV_CONTROL   = 4'd3;
  localparam logic [3:0] EV_PROGRAM   = 4'd4;
  localparam logic [3:0] EV_CHANPRESS = 4'd5;
  localparam logic [3:0] EV_PITCH     = 4'd6;
  localparam logic [3:0] EV_TEMPO     = 4'd7;
  localparam logic [3:0] EV_SYSEX     = 4'd8;
  localparam logic [3:0] EV_END       = 4'd9;
  localparam logic [3:0] EV_ERROR     = 4'd10;

  localparam logic [7:0] META_END   = 8'h2F;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] META_TSIG  = 8'h58;
  localparam logic [7:0] META_KSIG  = 8'h59;

  localparam logic [15:0] SYSEX_LIMIT_RESET = 16'd4096;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  event_kind;
    logic [3:0]  channel;
    logic [7:0]  value_a;
    logic [7:0]  value_b;
    logic [14:0] wheel;
    logic [23:0] tempo;
    logic [31:0] delta_ticks;
    logic [31:0] total_ticks;
    logic [15:0] channels_used;
    logic        patch_valid;
    logic [7:0]  patch_index;
    logic [15:0] sysex_length;
  } out_item_t;

endpackage

### rtl/core/mtep_parser.sv
`timescale 1ns / 1ps
// Byte-level parser state: one request updates the state and may yield one event.
module mtep_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  mtep_pkg::in_item_t item,
  input  logic [15:0]        sysex_limit,
  output logic               emit,
  output mtep_pkg::out_item_t ev
);
  import mtep_pkg::*;

  logic [3:0]  phase, phase_next;
  logic [7:0]  running_status, running_status_next;
  logic [31:0] vlq, vlq_next;
  logic [31:0] pending_delta, pending_delta_next;
  logic [31:0] ignored_delta, ignored_delta_next;
  logic [31:0] tick_total, tick_total_next;
  logic [7:0]  first_data, first_data_next;
  logic [7:0]  meta_subtype, meta_subtype_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [23:0] tempo_shift, tempo_shift_next;
  logic [15:0] channel_mask, channel_mask_next;
  logic        track_done, track_done_next;

  logic [7:0]  b;
  logic [3:0]  ph;
  logic [7:0]  st;
  logic [31:0] vlq_shift;
  logic [31:0] bl_dec;
  logic        fire, fire_err, fire_ign;
  logic [3:0]  ch;
  logic [7:0]  a;
  logic [7:0]  b2;
  logic        st_ok;

  assign b = item.data_byte;
  assign vlq_shift = {vlq[24:0], b[6:0]};
  assign bl_dec = bytes_left - 32'd1;

  always_comb begin
    phase_next = phase;
    running_status_next = running_status;
    vlq_next = vlq;
    pending_delta_next = pending_delta;
    ignored_delta_next = ignored_delta;
    tick_total_next = tick_total;
    first_data_next = first_data;
    meta_subtype_next = meta_subtype;
    bytes_left_next = bytes_left;
    tempo_shift_next = tempo_shift;
    channel_mask_next = channel_mask;
    track_done_next = track_done;
    fire = 1'b0;
    fire_err = 1'b0;
    fire_ign = 1'b0;
    ev = '0;
    ch = running_status[3:0];
    a = first_data;
    b2 = 8'd0;
    st = running_status;
    st_ok = 1'b1;

    // Status position: a data byte falls through to the running-status phase.
    ph = phase;
    if (phase == PH_STATUS) begin
      if (b[7]) begin
        st = b;
        running_status_next = b;
      end
      if (st == 8'hFF) begin
        ph = PH_META_TYPE;
      end else if (st >= 8'hF0 && st <= 8'hF7) begin
        ph = PH_SYSEX_LEN;
      end else if (st >= 8'h80 && st <= 8'hEF) begin
        ph = PH_CH1;
      end else begin
        st_ok = 1'b0;
      end
    end

    if (phase == PH_STATUS && (b[7] || !st_ok)) begin
      if (!st_ok) begin
        fire_err = 1'b1;
      end else begin
        phase_next = ph;
        if (ph == PH_SYSEX_LEN) vlq_next = '0;
      end
    end else begin
      // vlq is cleared whenever sysex len phase is entered from status
      if (phase == PH_STATUS && ph == PH_SYSEX_LEN) vlq_next = '0;
      case (ph)
        PH_DELTA: begin
          vlq_next = vlq_shift;
          if (!b[7]) begin
            pending_delta_next = vlq_shift;
            tick_total_next = tick_total + vlq_shift;
            vlq_next = '0;
            phase_next = PH_STATUS;
          end
        end
        PH_CH1: begin
          first_data_next = b;
          a = b;
          if (st[7:4] == 4'hC || st[7:4] == 4'hD) begin
            fire = 1'b1;
          end else begin
            phase_next = PH_CH2;
          end
        end
        PH_CH2: begin
          fire = 1'b1;
          b2 = b;
        end
        PH_META_TYPE: begin
          meta_subtype_next = b;
          vlq_next = '0;
          phase_next = PH_META_LEN;
        end
        PH_META_LEN: begin
          vlq_next = vlq_shift;
          if (!b[7]) begin
            bytes_left_next = vlq_shift;
            vlq_next = '0;
            if (meta_subtype == META_END) begin
              fire = 1'b1;
            end else if (meta_subtype == META_TEMPO) begin
              if (vlq_shift != 32'd3) begin
                fire_err = 1'b1;
              end else begin
                tempo_shift_next = '0;
                phase_next = PH_TEMPO;
              end
            end else if ((meta_subtype == META_TSIG && vlq_shift != 32'd4) ||
                         (meta_subtype == META_KSIG && vlq_shift != 32'd2)) begin
              fire_err = 1'b1;
            end else if (vlq_shift == 32'd0) begin
              fire_ign = 1'b1;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
        PH_TEMPO: begin
          tempo_shift_next = {tempo_shift[15:0], b};
          bytes_left_next = bl_dec;
          if (bl_dec == 32'd0) fire = 1'b1;
        end
        PH_SKIP: begin
          bytes_left_next = bl_dec;
          if (bl_dec == 32'd0) fire_ign = 1'b1;
        end
        PH_SYSEX_LEN: begin
          // from status the accumulator starts at zero
          vlq_next = (phase == PH_STATUS) ? {25'd0, b[6:0]} : vlq_shift;
          if (!b[7]) begin
            bytes_left_next = vlq_next;
            if (vlq_next >= {16'd0, sysex_limit}) begin
              if (vlq_next == 32'd0) fire_ign = 1'b1;
              else phase_next = PH_SKIP;
            end else begin
              vlq_next = vlq_next + 32'd1;
              if (bytes_left_next == 32'd0) fire = 1'b1;
              else phase_next = PH_SYSEX_BODY;
            end
          end
        end
        PH_SYSEX_BODY: begin
          bytes_left_next = bl_dec;
          if (bl_dec == 32'd0) fire = 1'b1;
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end

    // Build the event.
    if (fire) begin
      ev.delta_ticks = pending_delta + ignored_delta;
      ev.total_ticks = tick_total_next;
      case (ph)
        PH_CH1, PH_CH2: begin
          ev.channel = ch;
          case (st[7:4])
            4'h8: begin
              ev.event_kind = EV_NOTEOFF; ev.value_a = {1'b0, a[6:0]}; ev.value_b = b2;
            end
            4'h9: begin
              ev.event_kind = (b2 == 8'd0) ? EV_NOTEOFF : EV_NOTEON;
              ev.value_a = {1'b0, a[6:0]};
              ev.value_b = b2;
              if (b2 != 8'd0) channel_mask_next = channel_mask | (16'd1 << ch);
              if (ch == 4'd9) begin
                ev.patch_valid = 1'b1;
                ev.patch_index = {1'b1, a[6:0]};
              end
            end
            4'hA: begin
              ev.event_kind = EV_KEYPRESS; ev.value_a = a; ev.value_b = b2;
            end
            4'hB: begin
              ev.event_kind = EV_CONTROL; ev.value_a = a; ev.value_b = b2;
            end
            4'hC: begin
              ev.event_kind = EV_PROGRAM; ev.value_a = {1'b0, a[6:0]};
              ev.patch_valid = 1'b1; ev.patch_index = {1'b0, a[6:0]};
            end
            4'hD: begin
              ev.event_kind = EV_CHANPRESS; ev.value_a = a;
            end
            default: begin
              // the first byte's top bit overlaps the second byte's low bit
              ev.event_kind = EV_PITCH; ev.wheel = {b2, 7'd0} | {7'd0, a};
            end
          endcase
        end
        PH_META_LEN: begin
          ev.event_kind = EV_END;
          track_done_next = 1'b1;
        end
        PH_TEMPO: begin
          ev.event_kind = EV_TEMPO;
          ev.tempo = tempo_shift_next;
        end
        default: begin
          ev.event_kind = EV_SYSEX;
          ev.sysex_length = vlq_next[15:0];
        end
      endcase
      ev.channels_used = channel_mask_next;
      ignored_delta_next = '0;
      phase_next = PH_DELTA;
      vlq_next = '0;
      pending_delta_next = '0;
    end else if (fire_err) begin
      ev.event_kind = EV_ERROR;
      ev.total_ticks = tick_total;
      ev.channels_used = channel_mask;
      track_done_next = 1'b1;
    end else if (fire_ign) begin
      ignored_delta_next = ignored_delta + pending_delta;
      phase_next = PH_DELTA;
      vlq_next = '0;
      pending_delta_next = '0;
    end
  end

  assign emit = step && !item.action && !track_done && (fire || fire_err);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DELTA;
      running_status <= '0;
      vlq <= '0;
      pending_delta <= '0;
      ignored_delta <= '0;
      tick_total <= '0;
      first_data <= '0;
      meta_subtype <= '0;
      bytes_left <= '0;
      tempo_shift <= '0;
      channel_mask <= '0;
      track_done <= 1'b0;
    end else if (step) begin
      if (item.action) begin
        phase <= PH_DELTA;
        running_status <= '0;
        vlq <= '0;
        pending_delta <= '0;
        ignored_delta <= '0;
        tick_total <= '0;
        first_data <= '0;
        meta_subtype <= '0;
        bytes_left <= '0;
        tempo_shift <= '0;
        track_done <= 1'b0;
      end else if (!track_done) begin
        phase <= phase_next;
        running_status <= running_status_next;
        vlq <= vlq_next;
        pending_delta <= pending_delta_next;
        ignored_delta <= ignored_delta_next;
        tick_total <= tick_total_next;
        first_data <= first_data_next;
        meta_subtype <= meta_subtype_next;
        bytes_left <= bytes_left_next;
        tempo_shift <= tempo_shift_next;
        channel_mask <= channel_mask_next;
        track_done <= track_done_next;
      end
    end
  end

endmodule

### rtl/core/midi_track_event_parser_core.sv
`timescale 1ns / 1ps
// MIDI track event parser.
// Input channel (in_valid/in_stall, in_item): one track byte per request, or a
// start-of-track request (action = 1) that clears the parser but keeps the
// channel mask and the sysex limit. Output channel (out_valid/out_stall,
// out_item): at most one event per input byte.
// Configuration channel (cfg_valid/cfg_ready, cfg_data): sysex_limit, to be written
// by the user only while idle (the block does not enforce this); cfg_ready is always high.
// Each event is registered into out_item, or into the skid entry if stalled.
// Throughput: one byte per cycle while in_stall is low, set by the parser's
// per-byte update; the output register plus a one-entry skid buffer lets
// input run while the receiver stalls; in_stall rises only when skid is full.
// Reset (rst, synchronous): parser state, channel mask and both output entries
// clear, sysex_limit returns to 4096.
module midi_track_event_parser_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mtep_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mtep_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import mtep_pkg::*;

  logic [15:0] sysex_limit;
  logic        step;
  logic        emit;
  out_item_t   ev;
  logic        skid_valid;
  out_item_t   skid_item;

  assign cfg_ready = 1'b1;
  assign in_stall = skid_valid;
  assign step = in_valid && !in_stall;

  mtep_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (in_item),
    .sysex_limit (sysex_limit),
    .emit        (emit),
    .ev          (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sysex_limit <= SYSEX_LIMIT_RESET;
    end else if (cfg_valid) begin
      sysex_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        if (skid_valid) begin
          out_valid <= 1'b1;
          out_item <= skid_item;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= step && emit;
          if (step && emit) out_item <= ev;
        end
      end else if (step && emit) begin
        skid_valid <= 1'b1;
        skid_item <= ev;
      end
    end
  end

endmodule
